// ===== design/audio_fragment_ring_tracker_defines.svh =====
// Assertion macros for the fragment ring tracker checkers
`ifndef AUDIO_FRAGMENT_RING_TRACKER_DEFINES_SVH
`define AUDIO_FRAGMENT_RING_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define AFRT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define AFRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/afrt_pkg.sv =====
// Shared constants, codes, interface structs and helpers of the fragment ring tracker
package afrt_pkg;

	localparam int MAX_FRAGS     = 16;
	localparam int MAX_FRAG_SIZE = 4096;
	localparam int RESULT_LIMIT  = 16;

	localparam int CNT_W   = 5;
	localparam int SIZE_W  = 13;
	localparam int IDX_W   = 4;
	localparam int FILL_W  = 12;
	localparam int OFF_W   = 16;
	localparam int BYTES_W = 16;
	localparam int POS_W   = 13;
	localparam int DELAY_W = 17;
	localparam int NRES_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Input command codes
	typedef enum logic [1:0] {
		CMD_XFER      = 2'd0,
		CMD_FRAG_DONE = 2'd1,
		CMD_CLEAR     = 2'd2
	} cmd_code_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAG_COUNT  = 2'd0,
		CFG_FRAG_SIZE   = 2'd1,
		CFG_RECORD_MODE = 2'd2
	} cfg_reg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic exec;
		logic emit;
	} ctl_t;

	// Datapath to controller status, valid during exec
	typedef struct packed {
		logic emit;
		logic last;
	} stat_t;

	// Fragment count as used: 0 acts as 1, clipped at the ring size
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0) r = CNT_W'(1);
		else if (c > CNT_W'(MAX_FRAGS)) r = CNT_W'(MAX_FRAGS);
		return r;
	endfunction

	// Fragment size as used: 0 acts as 1, clipped at the maximum size
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s == '0) r = SIZE_W'(1);
		else if (s > SIZE_W'(MAX_FRAG_SIZE)) r = SIZE_W'(MAX_FRAG_SIZE);
		return r;
	endfunction

	// Ring index advance; anything at or past the last fragment wraps to 0
	function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] cnt);
		logic [IDX_W-1:0] r;
		r = idx + IDX_W'(1);
		if ({1'b0, idx} >= cnt - CNT_W'(1)) r = '0;
		return r;
	endfunction

endpackage

// ===== design/afrt_ctrl.sv =====
// Sequencing controller of the fragment ring tracker
module afrt_ctrl import afrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output ctl_t  ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_EXEC,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   pend_q;
	logic   last_q;

	// State, pending-result flag and final-result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_WAIT;
						pend_q  <= 1'b0;
					end
				end
				// products settle from the updated state
				S_WAIT: begin
					state_q <= pend_q ? S_EMIT : S_EXEC;
				end
				S_EXEC: begin
					pend_q  <= stat.emit;
					last_q  <= stat.last;
					state_q <= S_WAIT;
				end
				S_EMIT: begin
					pend_q  <= 1'b0;
					state_q <= last_q ? S_IDLE : S_EXEC;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands follow the state
	assign busy       = (state_q != S_IDLE);
	assign ctl.accept = (state_q == S_IDLE) && start;
	assign ctl.exec   = (state_q == S_EXEC);
	assign ctl.emit   = (state_q == S_EMIT);

endmodule

// ===== design/afrt_dp.sv =====
// Datapath of the fragment ring tracker: config, ring state, segment math, result registers
module afrt_dp import afrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl,
	output stat_t                 stat,
	input  logic [1:0]            cmd,
	input  logic [BYTES_W-1:0]    byte_count,
	input  logic [POS_W-1:0]      current_position,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_strobe,
	output logic [OFF_W-1:0]      seg_offset,
	output logic [SIZE_W-1:0]     seg_length,
	output logic                  last,
	output logic                  start_pulse,
	output logic                  stop_pulse,
	output logic                  running,
	output logic [CNT_W-1:0]      free_frags,
	output logic [IDX_W-1:0]      hw_index,
	output logic [DELAY_W-1:0]    delay_bytes
);

	// Configuration and ring state
	logic [CNT_W-1:0]  frag_count_q;
	logic [SIZE_W-1:0] frag_size_q;
	logic              record_q;
	logic [IDX_W-1:0]  sw_q;
	logic [IDX_W-1:0]  hw_q;
	logic [CNT_W-1:0]  credits_q;
	logic [FILL_W-1:0] fill_q;
	logic              run_q;
	logic              start_q;
	logic [NRES_W-1:0] nres_q;
	logic              strobe_q;

	// Latched item and per-result payload
	logic [1:0]         cmd_q;
	logic [BYTES_W-1:0] rem_q;
	logic [POS_W-1:0]   pos_q;
	logic [OFF_W-1:0]   base_q;
	logic [DELAY_W-1:0] prod_q;
	logic               seg_q;
	logic [OFF_W-1:0]   seg_off_q;
	logic [SIZE_W-1:0]  seg_len_q;
	logic               res_last_q;
	logic               res_start_q;
	logic               res_stop_q;
	logic [OFF_W-1:0]   seg_offset_q;
	logic [SIZE_W-1:0]  seg_length_q;
	logic               last_q;
	logic               start_pulse_q;
	logic               stop_pulse_q;
	logic               running_q;
	logic [CNT_W-1:0]   free_frags_q;
	logic [IDX_W-1:0]   hw_index_q;
	logic [DELAY_W-1:0] delay_bytes_q;

	logic [CNT_W-1:0]   cnt;
	logic [SIZE_W-1:0]  size;
	logic [CNT_W-1:0]   queued;
	logic [DELAY_W-1:0] base_full;
	logic [DELAY_W-1:0] prod_full;
	logic               has_room;
	logic [SIZE_W-1:0]  room;
	logic               no_credit;
	logic               has_seg;
	logic [SIZE_W-1:0]  seg_len;
	logic [SIZE_W-1:0]  fill_sum;
	logic               full;
	logic [BYTES_W-1:0] rem_next;
	logic [CNT_W-1:0]   credits_dec;
	logic [CNT_W-1:0]   credits_x;
	logic               start_x;
	logic [IDX_W-1:0]   hw_next;
	logic [CNT_W-1:0]   credits_inc;
	logic               stop_x;
	logic [OFF_W-1:0]   cur_off;
	logic [DELAY_W-1:0] d_sub;
	logic [DELAY_W-1:0] delay;

	assign cnt  = eff_count(frag_count_q);
	assign size = eff_size(frag_size_q);

	// Ring base and queued-bytes products, refreshed every cycle
	assign queued    = (cnt > credits_q) ? cnt - credits_q : '0;
	assign base_full = DELAY_W'(size) * DELAY_W'(sw_q);
	assign prod_full = DELAY_W'(size) * DELAY_W'(queued);

	// One copy iteration of a transfer
	assign has_room    = {1'b0, fill_q} < size;
	assign room        = size - {1'b0, fill_q};
	assign no_credit   = (credits_q == '0);
	assign has_seg     = !no_credit && (rem_q != '0) && has_room;
	assign seg_len     = ({3'b0, room} > rem_q) ? rem_q[SIZE_W-1:0] : room;
	assign fill_sum    = {1'b0, fill_q} + seg_len;
	assign full        = !no_credit && (has_seg ? (fill_sum >= size) : !has_room);
	assign rem_next    = has_seg ? rem_q - BYTES_W'(seg_len) : rem_q;
	assign credits_dec = credits_q - CNT_W'(1);
	assign credits_x   = full ? credits_dec : credits_q;
	assign start_x     = start_q | (full & !record_q);

	// Fragment-done update
	assign hw_next     = next_index(hw_q, cnt);
	assign credits_inc = (credits_q < cnt) ? credits_q + CNT_W'(1) : credits_q;
	assign stop_x      = (credits_inc == cnt);

	// Result decision for the controller
	always_comb begin
		stat.emit = 1'b1;
		stat.last = 1'b1;
		case (cmd_q)
			CMD_XFER: begin
				if (has_seg) begin
					stat.last = !(full && (rem_next != '0) &&
						(nres_q != NRES_W'(RESULT_LIMIT - 1)) && (credits_x != '0));
				end else begin
					stat.emit = no_credit || !full || (rem_q == '0);
				end
			end
			default: begin
				stat.emit = 1'b1;
				stat.last = 1'b1;
			end
		endcase
	end

	// Status fields at emit time
	assign cur_off = base_q + OFF_W'(fill_q);
	assign d_sub   = (prod_q > DELAY_W'(pos_q)) ? prod_q - DELAY_W'(pos_q) : '0;
	assign delay   = run_q ? d_sub + DELAY_W'(fill_q) : '0;

	// Config registers and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_count_q <= CNT_W'(MAX_FRAGS);
			frag_size_q  <= SIZE_W'(MAX_FRAG_SIZE);
			record_q     <= 1'b0;
			sw_q         <= '0;
			hw_q         <= '0;
			credits_q    <= CNT_W'(MAX_FRAGS);
			fill_q       <= '0;
			run_q        <= 1'b0;
			start_q      <= 1'b0;
			nres_q       <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= ctl.emit;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAG_COUNT:  frag_count_q <= cfg_data[CNT_W-1:0];
					CFG_FRAG_SIZE:   frag_size_q  <= cfg_data;
					CFG_RECORD_MODE: record_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (ctl.accept) begin
				nres_q  <= '0;
				start_q <= (cmd == CMD_XFER) && record_q;
				if ((cmd == CMD_XFER) && record_q) run_q <= 1'b1;
			end
			if (ctl.exec) begin
				case (cmd_q)
					CMD_XFER: begin
						if (full) begin
							sw_q      <= next_index(sw_q, cnt);
							credits_q <= credits_dec;
							fill_q    <= '0;
							if (!record_q) run_q <= 1'b1;
						end else if (has_seg) begin
							fill_q <= fill_sum[FILL_W-1:0];
						end
						start_q <= has_seg ? 1'b0 : start_x;
						if (has_seg) nres_q <= nres_q + NRES_W'(1);
					end
					CMD_FRAG_DONE: begin
						hw_q      <= hw_next;
						credits_q <= credits_inc;
						if (stop_x) run_q <= 1'b0;
					end
					CMD_CLEAR: begin
						sw_q      <= '0;
						hw_q      <= '0;
						credits_q <= record_q ? '0 : cnt;
						fill_q    <= '0;
						run_q     <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// Item latch, products and result payload
	always_ff @(posedge clk) begin
		base_q <= base_full[OFF_W-1:0];
		prod_q <= prod_full;
		if (ctl.accept) begin
			cmd_q <= cmd;
			rem_q <= byte_count;
			pos_q <= current_position;
		end
		if (ctl.exec) begin
			rem_q       <= rem_next;
			seg_q       <= (cmd_q == CMD_XFER) && has_seg;
			seg_off_q   <= cur_off;
			seg_len_q   <= seg_len;
			res_last_q  <= stat.last;
			res_start_q <= (cmd_q == CMD_XFER) && start_x;
			res_stop_q  <= (cmd_q == CMD_FRAG_DONE) && stop_x;
		end
		if (ctl.emit) begin
			seg_offset_q  <= seg_q ? seg_off_q : cur_off;
			seg_length_q  <= seg_q ? seg_len_q : '0;
			last_q        <= res_last_q;
			start_pulse_q <= res_start_q;
			stop_pulse_q  <= res_stop_q;
			running_q     <= run_q;
			free_frags_q  <= credits_q;
			hw_index_q    <= hw_q;
			delay_bytes_q <= delay;
		end
	end

	assign result_strobe = strobe_q;
	assign seg_offset    = seg_offset_q;
	assign seg_length    = seg_length_q;
	assign last          = last_q;
	assign start_pulse   = start_pulse_q;
	assign stop_pulse    = stop_pulse_q;
	assign running       = running_q;
	assign free_frags    = free_frags_q;
	assign hw_index      = hw_index_q;
	assign delay_bytes   = delay_bytes_q;

endmodule

// ===== design/audio_fragment_ring_tracker.sv =====
// Top level of the audio DMA fragment ring tracker
//
// Usage:
//   Command channel: an item (cmd, byte_count, current_position) transfers at a
//   rising edge with start high and busy low. cmd: transfer, fragment done, clear.
//   Result channel: each result is on the outputs for one cycle with
//   result_strobe high; the receiver has no way to stall it. last marks the
//   final result of an item, after which busy is already low.
//   Config port: cfg_we/cfg_index/cfg_data write frag_count, frag_size and
//   record_mode; write only while busy is low.
// Timing:
//   Each result passes through the state update, the product settle and the result
//   register. A transfer that first closes an overfull fragment passes through an
//   extra state update before its first result. The port takes a new item only
//   after the last result of the previous one, when busy is low again. The product
//   registers between state update and result set this pacing.
// Reset:
//   arst_n low returns to idle, 16 fragments of 4096 bytes, playback, all
//   indexes and fill at 0, 16 credits, stream stopped.
module audio_fragment_ring_tracker import afrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [BYTES_W-1:0]    byte_count,
	input  logic [POS_W-1:0]      current_position,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_strobe,
	output logic [OFF_W-1:0]      seg_offset,
	output logic [SIZE_W-1:0]     seg_length,
	output logic                  last,
	output logic                  start_pulse,
	output logic                  stop_pulse,
	output logic                  running,
	output logic [CNT_W-1:0]      free_frags,
	output logic [IDX_W-1:0]      hw_index,
	output logic [DELAY_W-1:0]    delay_bytes
);

	ctl_t  ctl;
	stat_t stat;

	// Sequencer
	afrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Ring state and result datapath
	afrt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.cmd              (cmd),
		.byte_count       (byte_count),
		.current_position (current_position),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_strobe    (result_strobe),
		.seg_offset       (seg_offset),
		.seg_length       (seg_length),
		.last             (last),
		.start_pulse      (start_pulse),
		.stop_pulse       (stop_pulse),
		.running          (running),
		.free_frags       (free_frags),
		.hw_index         (hw_index),
		.delay_bytes      (delay_bytes)
	);

endmodule

// ===== design/afrt_chk.sv =====
// Port-level checker of the fragment ring tracker and its bind
`include "audio_fragment_ring_tracker_defines.svh"

module afrt_chk import afrt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_strobe,
	input logic [SIZE_W-1:0] seg_length,
	input logic              last,
	input logic              start_pulse,
	input logic              stop_pulse,
	input logic              running
);

	// An accepted command occupies the block in the next cycle
	`AFRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after a command transfer")

	// The final result of an item finds the block idle again
	`AFRT_ASSERT_SAME(a_last_idle, result_strobe && last, !busy, "busy high with final result")

	// A result without a segment is always the only and final one
	`AFRT_ASSERT_SAME(a_empty_last, result_strobe && (seg_length == '0), last,
		"empty result not marked last")

	// A stop request leaves the stream stopped and never pairs with a start
	`AFRT_ASSERT_SAME(a_stop_state, result_strobe && stop_pulse, !running && !start_pulse,
		"stop result with stream running or start requested")

endmodule

bind audio_fragment_ring_tracker afrt_chk u_afrt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.seg_length    (seg_length),
	.last          (last),
	.start_pulse   (start_pulse),
	.stop_pulse    (stop_pulse),
	.running       (running)
);

// ===== bench/tb.sv =====
// Testbench for the audio fragment ring tracker: directed plan, then random phases
`timescale 1ns / 1ps

module tb;
	import afrt_pkg::*;

	// cmd value with no meaning; the block just reports status
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	typedef struct packed {
		logic [OFF_W-1:0]   seg_offset;
		logic [SIZE_W-1:0]  seg_length;
		logic               last;
		logic               start_pulse;
		logic               stop_pulse;
		logic               running;
		logic [CNT_W-1:0]   free_frags;
		logic [IDX_W-1:0]   hw_index;
		logic [DELAY_W-1:0] delay_bytes;
	} ring_result_t;

	typedef struct packed {
		bit                    is_cfg;
		cfg_reg_t              reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [1:0]            op;
		logic [BYTES_W-1:0]    nbytes;
		logic [POS_W-1:0]      pos;
		bit                    typed;
		ring_result_t          want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            cmd;
	logic [BYTES_W-1:0]    byte_count;
	logic [POS_W-1:0]      current_position;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_strobe;
	logic [OFF_W-1:0]      seg_offset;
	logic [SIZE_W-1:0]     seg_length;
	logic                  last;
	logic                  start_pulse;
	logic                  stop_pulse;
	logic                  running;
	logic [CNT_W-1:0]      free_frags;
	logic [IDX_W-1:0]      hw_index;
	logic [DELAY_W-1:0]    delay_bytes;

	// Ring state mirror
	int unsigned reg_count, reg_size, reg_record;
	int unsigned sw_idx, hw_idx, credit_cnt, fill_bytes;
	bit          run_on;

	ring_result_t ring_results_due[$];
	ring_result_t item_results[$];
	plan_row_t    plan[$];
	int unsigned  fail_count = 0;
	int unsigned  gap_pct = 34;

	audio_fragment_ring_tracker DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.byte_count       (byte_count),
		.current_position (current_position),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_strobe    (result_strobe),
		.seg_offset       (seg_offset),
		.seg_length       (seg_length),
		.last             (last),
		.start_pulse      (start_pulse),
		.stop_pulse       (stop_pulse),
		.running          (running),
		.free_frags       (free_frags),
		.hw_index         (hw_index),
		.delay_bytes      (delay_bytes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register values as the block uses them: 0 acts as 1, clipped at the maxima
	function automatic int unsigned count_in_use();
		if (reg_count == 0) return 1;
		if (reg_count > MAX_FRAGS) return MAX_FRAGS;
		return reg_count;
	endfunction

	function automatic int unsigned size_in_use();
		if (reg_size == 0) return 1;
		if (reg_size > MAX_FRAG_SIZE) return MAX_FRAG_SIZE;
		return reg_size;
	endfunction

	// Any index at or past the last fragment wraps to 0
	function automatic int unsigned step_index(input int unsigned idx);
		if (idx + 1 >= count_in_use()) return 0;
		return idx + 1;
	endfunction

	function automatic int unsigned write_ptr();
		return sw_idx * size_in_use() + fill_bytes;
	endfunction

	// Bytes queued ahead of the hardware, floored at zero
	function automatic int unsigned queued_delay(input int unsigned pos);
		int unsigned cnt, queued, d;
		cnt = count_in_use();
		if (!run_on) return 0;
		queued = (cnt > credit_cnt) ? cnt - credit_cnt : 0;
		d = 0;
		if (queued > 0) begin
			d = queued * size_in_use();
			d = (d > pos) ? d - pos : 0;
		end
		return d + fill_bytes;
	endfunction

	// One result carrying the status as it stands now
	function automatic ring_result_t ring_status(input int unsigned off, input int unsigned len,
			input bit st, input bit sp, input int unsigned pos);
		ring_result_t r;
		r.seg_offset  = off[OFF_W-1:0];
		r.seg_length  = len[SIZE_W-1:0];
		r.last        = 1'b0;
		r.start_pulse = st;
		r.stop_pulse  = sp;
		r.running     = run_on;
		r.free_frags  = credit_cnt[CNT_W-1:0];
		r.hw_index    = hw_idx[IDX_W-1:0];
		r.delay_bytes = DELAY_W'(queued_delay(pos));
		return r;
	endfunction

	// Works out the results of one item into item_results and advances the mirror
	function automatic void predict_ring_step(input logic [1:0] op, input int unsigned nbytes,
			input int unsigned pos);
		int unsigned size, cnt, rem, off, len, n;
		bit          startp, stopp, seg, full;
		item_results.delete();
		rem = nbytes;
		n = 0;
		if (op == CMD_XFER) begin
			size = size_in_use();
			startp = 1'b0;
			if (reg_record != 0) begin
				startp = 1'b1;
				run_on = 1'b1;
			end
			while (n < RESULT_LIMIT) begin
				seg = 1'b0;
				off = 0;
				len = 0;
				if (credit_cnt == 0) break;
				if (rem > 0 && fill_bytes < size) begin
					len = size - fill_bytes;
					if (len > rem) len = rem;
					off = write_ptr();
					rem -= len;
					fill_bytes += len;
					seg = 1'b1;
				end
				full = (fill_bytes >= size);
				if (full) begin
					sw_idx = step_index(sw_idx);
					credit_cnt--;
					fill_bytes = 0;
					if (reg_record == 0) begin
						startp = 1'b1;
						run_on = 1'b1;
					end
				end
				if (seg) begin
					item_results.push_back(ring_status(off, len, startp, 1'b0, pos));
					n++;
					startp = 1'b0;
				end
				if (!full || rem == 0) break;
			end
			// nothing copied: one status result with any pending pulse
			if (n == 0) item_results.push_back(ring_status(write_ptr(), 0, startp, 1'b0, pos));
		end else if (op == CMD_FRAG_DONE) begin
			cnt = count_in_use();
			stopp = 1'b0;
			hw_idx = step_index(hw_idx);
			if (credit_cnt < cnt) credit_cnt++;
			if (credit_cnt == cnt) begin
				stopp = 1'b1;
				run_on = 1'b0;
			end
			item_results.push_back(ring_status(write_ptr(), 0, 1'b0, stopp, pos));
		end else begin
			if (op == CMD_CLEAR) begin
				sw_idx = 0;
				hw_idx = 0;
				credit_cnt = (reg_record != 0) ? 0 : count_in_use();
				fill_bytes = 0;
				run_on = 1'b0;
			end
			item_results.push_back(ring_status(write_ptr(), 0, 1'b0, 1'b0, pos));
		end
		item_results[item_results.size()-1].last = 1'b1;
	endfunction

	// Hand-typed single status result (last set, no segment)
	function automatic ring_result_t status_word(input int unsigned off, input bit st,
			input bit sp, input bit run, input int unsigned free, input int unsigned hw,
			input int unsigned dly);
		ring_result_t r;
		r.seg_offset  = off[OFF_W-1:0];
		r.seg_length  = '0;
		r.last        = 1'b1;
		r.start_pulse = st;
		r.stop_pulse  = sp;
		r.running     = run;
		r.free_frags  = free[CNT_W-1:0];
		r.hw_index    = hw[IDX_W-1:0];
		r.delay_bytes = dly[DELAY_W-1:0];
		return r;
	endfunction

	function automatic void plan_cfg(input cfg_reg_t sel, input int unsigned val);
		plan_row_t p;
		p = '0;
		p.is_cfg  = 1'b1;
		p.reg_sel = sel;
		p.reg_val = val[CFG_DATA_W-1:0];
		plan.push_back(p);
	endfunction

	function automatic void plan_item(input logic [1:0] op, input int unsigned nbytes,
			input int unsigned pos, input bit typed, input ring_result_t want);
		plan_row_t p;
		p = '0;
		p.op     = op;
		p.nbytes = nbytes[BYTES_W-1:0];
		p.pos    = pos[POS_W-1:0];
		p.typed  = typed;
		p.want   = want;
		plan.push_back(p);
	endfunction

	// Register write at the current falling edge; caller lowers cfg_we after the last one
	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		case (sel)
			CFG_FRAG_COUNT:  reg_count  = val[CNT_W-1:0];
			CFG_FRAG_SIZE:   reg_size   = val;
			CFG_RECORD_MODE: reg_record = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Wait until every expected result is in and the block has settled
	task automatic drain_ring();
		start <= 1'b0;
		while (ring_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// Offer one item, with random gaps ahead of it; predict at the transfer edge
	task automatic send_item(input logic [1:0] op, input logic [BYTES_W-1:0] nbytes,
			input logic [POS_W-1:0] pos, input bit typed, input ring_result_t want);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start            <= 1'b1;
		cmd              <= op;
		byte_count       <= nbytes;
		current_position <= pos;
		do @(posedge clk); while (busy !== 1'b0);
		predict_ring_step(op, nbytes, pos);
		if (typed) ring_results_due.push_back(want);
		else foreach (item_results[k]) ring_results_due.push_back(item_results[k]);
		@(negedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Result monitor: every strobe is matched against the oldest expectation
	always @(posedge clk) begin
		ring_result_t want;
		if (arst_n === 1'b1 && result_strobe === 1'b1) begin
			if (ring_results_due.size() == 0) begin
				$error("result with none expected: seg_offset %0d seg_length %0d",
					seg_offset, seg_length);
				fail_count++;
			end else begin
				want = ring_results_due.pop_front();
				check_field("seg_offset", want.seg_offset, seg_offset);
				check_field("seg_length", want.seg_length, seg_length);
				check_field("last", want.last, last);
				check_field("start_pulse", want.start_pulse, start_pulse);
				check_field("stop_pulse", want.stop_pulse, stop_pulse);
				check_field("running", want.running, running);
				check_field("free_frags", want.free_frags, free_frags);
				check_field("hw_index", want.hw_index, hw_index);
				check_field("delay_bytes", want.delay_bytes, delay_bytes);
			end
		end
	end

	// Stimulus
	initial begin
		ring_result_t none;
		int unsigned  random_items, phase_len, roll, size, nbytes, pos, cnt_val, size_val;
		none = '0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_XFER;
		byte_count = '0;
		current_position = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAG_COUNT;
		cfg_data = '0;
		reg_count = 16;
		reg_size = 4096;
		reg_record = 0;
		sw_idx = 0;
		hw_idx = 0;
		credit_cnt = 16;
		fill_bytes = 0;
		run_on = 1'b0;

		// Directed plan: reset values, extremes, every command and each corner case
		plan_item(CMD_CLEAR, 0, 0, 1, status_word(0, 0, 0, 0, 16, 0, 0));
		// fragment done with all credits home: stop pulse even though stopped
		plan_item(CMD_FRAG_DONE, 0, 0, 1, status_word(0, 0, 1, 0, 16, 1, 0));
		plan_item(CMD_RESERVED, 65535, 8191, 1, status_word(0, 0, 0, 0, 16, 1, 0));
		plan_item(CMD_XFER, 0, 0, 1, status_word(0, 0, 0, 0, 16, 1, 0));
		plan_item(CMD_XFER, 65535, 0, 0, none);
		plan_item(CMD_XFER, 1, 100, 0, none);
		plan_item(CMD_XFER, 100, 0, 0, none);          // no credit left
		plan_item(CMD_FRAG_DONE, 0, 8191, 0, none);
		plan_item(CMD_FRAG_DONE, 0, 4096, 0, none);
		plan_item(CMD_XFER, 3000, 0, 0, none);
		// shrink the size under a partial fragment: it closes without a segment
		plan_cfg(CFG_FRAG_SIZE, 100);
		plan_item(CMD_XFER, 50, 10, 0, none);
		plan_item(CMD_FRAG_DONE, 0, 0, 0, none);
		plan_item(CMD_FRAG_DONE, 0, 0, 0, none);
		// more credits than fragments, hardware index past the count
		plan_cfg(CFG_FRAG_COUNT, 1);
		plan_item(CMD_FRAG_DONE, 0, 50, 0, none);
		plan_item(CMD_XFER, 500, 0, 0, none);
		plan_item(CMD_CLEAR, 0, 0, 0, none);
		// out-of-range registers clip at the maxima
		plan_cfg(CFG_FRAG_COUNT, 31);
		plan_cfg(CFG_FRAG_SIZE, 8191);
		plan_item(CMD_XFER, 5000, 4096, 0, none);
		// zero registers act as 1
		plan_cfg(CFG_FRAG_COUNT, 0);
		plan_cfg(CFG_FRAG_SIZE, 0);
		plan_item(CMD_CLEAR, 0, 0, 0, none);
		plan_item(CMD_XFER, 3, 0, 0, none);
		// record mode: clear leaves no credit, transfer still starts the stream
		plan_cfg(CFG_RECORD_MODE, 1);
		plan_cfg(CFG_FRAG_COUNT, 16);
		plan_cfg(CFG_FRAG_SIZE, 4000);
		plan_item(CMD_CLEAR, 0, 0, 0, none);
		plan_item(CMD_XFER, 10, 0, 1, status_word(0, 1, 0, 1, 0, 0, 64000));
		plan_cfg(CFG_RECORD_MODE, 0);
		// 16 full fragments in one item: result limit
		plan_item(CMD_CLEAR, 0, 0, 0, none);
		plan_item(CMD_XFER, 65535, 0, 0, none);
		plan_item(CMD_FRAG_DONE, 0, 4000, 0, none);
		plan_cfg(CFG_FRAG_SIZE, 4096);
		plan_item(CMD_CLEAR, 0, 0, 0, none);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (i == 0 || !plan[i-1].is_cfg) drain_ring();
				write_reg(plan[i].reg_sel, plan[i].reg_val);
				if (i == plan.size() - 1 || !plan[i+1].is_cfg) cfg_we <= 1'b0;
			end else begin
				send_item(plan[i].op, plan[i].nbytes, plan[i].pos, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: new registers while idle, then a run of items
		random_items = 0;
		while (random_items < 250) begin
			drain_ring();
			roll = $urandom_range(0, 99);
			if (roll < 70) cnt_val = $urandom_range(1, 16);
			else if (roll < 80) cnt_val = 16;
			else if (roll < 90) cnt_val = 1;
			else cnt_val = $urandom_range(0, 31);
			roll = $urandom_range(0, 99);
			if (roll < 40) size_val = $urandom_range(1, 64);
			else if (roll < 65) size_val = $urandom_range(65, 4096);
			else if (roll < 75) size_val = 4096;
			else if (roll < 85) size_val = 1;
			else size_val = $urandom_range(0, 8191);
			write_reg(CFG_FRAG_COUNT, cnt_val[CFG_DATA_W-1:0]);
			write_reg(CFG_FRAG_SIZE, size_val[CFG_DATA_W-1:0]);
			write_reg(CFG_RECORD_MODE, CFG_DATA_W'(($urandom_range(0, 99) < 30) ? 1 : 0));
			cfg_we <= 1'b0;
			if ($urandom_range(0, 99) < 70)
				send_item(CMD_CLEAR, BYTES_W'($urandom), POS_W'($urandom), 0, none);
			size = size_in_use();
			phase_len = $urandom_range(10, 40);
			repeat (phase_len) begin
				// a long stretch without gaps
				gap_pct = (random_items >= 100 && random_items < 160) ? 0 : 34;
				roll = $urandom_range(0, 99);
				if (roll < 15) nbytes = $urandom_range(0, 65535);
				else if (roll < 30) nbytes = $urandom_range(0, 16);
				else nbytes = (size * 2 > 65535) ? $urandom_range(0, 65535)
					: $urandom_range(0, size * 2);
				pos = ($urandom_range(0, 99) < 80) ? $urandom_range(0, size)
					: $urandom_range(0, 8191);
				roll = $urandom_range(0, 99);
				if (roll < 52)
					send_item(CMD_XFER, nbytes[BYTES_W-1:0], pos[POS_W-1:0], 0, none);
				else if (roll < 87)
					send_item(CMD_FRAG_DONE, nbytes[BYTES_W-1:0], pos[POS_W-1:0], 0, none);
				else if (roll < 94)
					send_item(CMD_CLEAR, nbytes[BYTES_W-1:0], pos[POS_W-1:0], 0, none);
				else
					send_item(CMD_RESERVED, nbytes[BYTES_W-1:0], pos[POS_W-1:0], 0, none);
				random_items++;
			end
		end

		start <= 1'b0;
		while (ring_results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && ring_results_due.size() == 0) begin
			$display("audio_fragment_ring_tracker test passed");
		end else begin
			$display("audio_fragment_ring_tracker test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("audio_fragment_ring_tracker test failed");
		$finish;
	end

endmodule
